@@ rtl/core/prq_pkg.sv @@
`default_nettype none
package prq_pkg;

  localparam int PRQ_DEPTH = 64;
  localparam int PID_W     = 6;
  localparam int PRIO_W    = 3;
  localparam int OP_W      = 2;
  localparam int ST_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_REMOVE  = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage
`default_nettype wire

@@ rtl/core/prq_ctrl.sv @@
`default_nettype none
module prq_ctrl
  import prq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      cmd
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC: begin
        cmd.exec = !out_valid || out_ready;
      end
      default: ;
    endcase
    if (cmd.exec) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/prq_datapath.sv @@
`default_nettype none
module prq_datapath
  import prq_pkg::*;
#(
  parameter int QUEUE_DEPTH = PRQ_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  input  wire logic [OP_W-1:0]   op,
  input  wire logic [PID_W-1:0]  entry_pid,
  input  wire logic [PRIO_W-1:0] entry_priority,
  input  wire logic              rotate,
  output logic      [PID_W-1:0]  out_pid,
  output logic      [ST_W-1:0]   status
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [OP_W-1:0]   req_op;
  logic [PID_W-1:0]  req_pid;
  logic [PRIO_W-1:0] req_prio;
  logic              req_rot;

  logic [PID_W-1:0]  slot_pid      [QUEUE_DEPTH];
  logic [PRIO_W-1:0] slot_priority [QUEUE_DEPTH];
  logic [CNT_W-1:0]  occupancy, occupancy_next;

  logic [PID_W-1:0]  up_pid  [QUEUE_DEPTH];
  logic [PRIO_W-1:0] up_prio [QUEUE_DEPTH];
  logic [PID_W-1:0]  dn_pid  [QUEUE_DEPTH];
  logic [PRIO_W-1:0] dn_prio [QUEUE_DEPTH];

  logic [QUEUE_DEPTH-1:0] cell_valid, gt_vec, gt_prev, match_vec, tail_vec;
  logic [QUEUE_DEPTH-1:0] seen_vec, shl_vec;
  logic                   full, empty, found, rot_sel, do_ins;
  logic [PID_W-1:0]       res_pid;
  status_t                res_status;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op   <= op;
      req_pid  <= entry_pid;
      req_prio <= entry_priority;
      req_rot  <= rotate;
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_valid[i] = CNT_W'(i) < occupancy;
      gt_vec[i]     = cell_valid[i] && (slot_priority[i] > req_prio);
      match_vec[i]  = cell_valid[i] && (slot_pid[i] == req_pid);
      tail_vec[i]   = CNT_W'(i) == occupancy;
    end
    gt_prev = {gt_vec[QUEUE_DEPTH-2:0], 1'b0};
  end

  always_comb begin
    seen_vec = match_vec;
    for (int s = 1; s < QUEUE_DEPTH; s = s * 2) begin
      seen_vec = seen_vec | (seen_vec << s);
    end
  end

  always_comb begin
    up_pid[0]  = req_pid;
    up_prio[0] = req_prio;
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      up_pid[i]  = slot_pid[i-1];
      up_prio[i] = slot_priority[i-1];
    end
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      dn_pid[i]  = slot_pid[i+1];
      dn_prio[i] = slot_priority[i+1];
    end
    dn_pid[QUEUE_DEPTH-1]  = slot_pid[QUEUE_DEPTH-1];
    dn_prio[QUEUE_DEPTH-1] = slot_priority[QUEUE_DEPTH-1];
  end

  always_comb begin
    full           = occupancy == CNT_W'(QUEUE_DEPTH);
    empty          = occupancy == '0;
    found          = seen_vec[QUEUE_DEPTH-1];
    rot_sel        = req_rot && (occupancy >= CNT_W'(2))
                     && (slot_priority[1] == slot_priority[0]);
    do_ins         = 1'b0;
    shl_vec        = '0;
    occupancy_next = occupancy;
    res_pid        = '0;
    res_status     = ST_OK;
    unique case (req_op)
      OP_ENQUEUE: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          do_ins         = 1'b1;
          occupancy_next = occupancy + CNT_W'(1);
        end
      end
      OP_DEQUEUE: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          shl_vec        = rot_sel ? {{(QUEUE_DEPTH-1){1'b1}}, 1'b0} : '1;
          res_pid        = rot_sel ? slot_pid[1] : slot_pid[0];
          occupancy_next = occupancy - CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (!found) begin
          res_status = ST_NOT_FOUND;
        end else begin
          shl_vec        = seen_vec;
          occupancy_next = occupancy - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (do_ins && (gt_vec[i] || tail_vec[i])) begin
          slot_pid[i]      <= gt_prev[i] ? up_pid[i] : req_pid;
          slot_priority[i] <= gt_prev[i] ? up_prio[i] : req_prio;
        end else if (shl_vec[i]) begin
          slot_pid[i]      <= dn_pid[i];
          slot_priority[i] <= dn_prio[i];
        end
      end
      out_pid <= res_pid;
      status  <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (cmd.exec) begin
      occupancy <= occupancy_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/priority_ready_queue.sv @@
// Ready queue for a scheduler, held sorted by priority (a lower number is
// more urgent), with equal priorities kept in arrival order.
// The request channel (in_valid, in_ready) carries op, entry_pid,
// entry_priority and rotate; the result channel (out_valid, out_ready)
// carries out_pid and status. Every request gives exactly one result.
// Each entry sits in a cell of its own, and all cells compare against the
// request in parallel, so an insert, pop or remove moves the whole row by
// at most one place, all cells at once.
// A request is registered in the cycle of its transfer and executed once the
// output register is free, and its result is then registered there. The block
// takes a new request only after the load and execute steps of the controller
// are done with the last one, and holds one request at a time.
// While the receiver stalls, the result stays in the output register and one
// further request may be taken; it waits until the output register frees.
// Reset empties the queue and drops any pending result.
`default_nettype none
module priority_ready_queue
  import prq_pkg::*;
#(
  parameter int QUEUE_DEPTH = PRQ_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [OP_W-1:0]   op,
  input  wire logic [PID_W-1:0]  entry_pid,
  input  wire logic [PRIO_W-1:0] entry_priority,
  input  wire logic              rotate,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [PID_W-1:0]  out_pid,
  output logic      [ST_W-1:0]   status
);

  cmd_t cmd;

  prq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  prq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .op             (op),
    .entry_pid      (entry_pid),
    .entry_priority (entry_priority),
    .rotate         (rotate),
    .out_pid        (out_pid),
    .status         (status)
  );

endmodule
`default_nettype wire

@@ rtl/core/prq_checker.sv @@
`default_nettype none
module prq_checker
  import prq_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [PID_W-1:0]  out_pid,
  input wire logic [ST_W-1:0]   status
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_pid) && $stable(status))
    else $error("result changed while stalled");

  // Only one request is in flight, so a transfer closes the request channel.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another executes");

  // Failed operations never report a process id.
  a_fail_no_pid: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> out_pid == '0)
    else $error("process id reported with a failure status");

  // Reset drops any pending result.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind priority_ready_queue prq_checker u_prq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_pid   (out_pid),
  .status    (status)
);
`default_nettype wire

@@ sim/tb_priority_ready_queue.sv @@
`timescale 1ns / 1ps
module tb_priority_ready_queue;
  import prq_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [PID_W-1:0] pid;
    status_t          st;
  } outcome_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   op = '0;
  logic [PID_W-1:0]  entry_pid = '0;
  logic [PRIO_W-1:0] entry_priority = '0;
  logic              rotate = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [PID_W-1:0]  out_pid;
  logic [ST_W-1:0]   status;

  logic [PID_W-1:0]  ready_pid [PRQ_DEPTH];
  logic [PRIO_W-1:0] ready_prio [PRQ_DEPTH];
  int                ready_count = 0;
  outcome_t          expected_results[$];
  int                mismatch_count = 0;
  int                sender_gap_pct = 0;
  int                receiver_stall_pct = 0;

  priority_ready_queue u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .entry_pid      (entry_pid),
    .entry_priority (entry_priority),
    .rotate         (rotate),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pid        (out_pid),
    .status         (status)
  );

  always #10 clk = ~clk;

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void remove_slot(int pos);
    for (int i = pos; i + 1 < ready_count; i++) begin
      ready_pid[i]  = ready_pid[i + 1];
      ready_prio[i] = ready_prio[i + 1];
    end
    ready_count--;
  endfunction

  function automatic outcome_t predict_outcome(logic [OP_W-1:0] req_op,
                                               logic [PID_W-1:0] req_pid,
                                               logic [PRIO_W-1:0] req_prio,
                                               logic req_rot);
    outcome_t res;
    int       pos;
    res.pid = '0;
    res.st  = ST_OK;
    pos     = 0;
    case (req_op)
      OP_ENQUEUE: begin
        if (ready_count >= PRQ_DEPTH) begin
          res.st = ST_FULL;
        end else begin
          while (pos < ready_count && ready_prio[pos] <= req_prio) pos++;
          for (int i = ready_count; i > pos; i--) begin
            ready_pid[i]  = ready_pid[i - 1];
            ready_prio[i] = ready_prio[i - 1];
          end
          ready_pid[pos]  = req_pid;
          ready_prio[pos] = req_prio;
          ready_count++;
        end
      end
      OP_DEQUEUE: begin
        if (ready_count == 0) begin
          res.st = ST_EMPTY;
        end else begin
          if (req_rot && ready_count >= 2 && ready_prio[1] == ready_prio[0]) pos = 1;
          res.pid = ready_pid[pos];
          remove_slot(pos);
        end
      end
      OP_REMOVE: begin
        while (pos < ready_count && ready_pid[pos] != req_pid) pos++;
        if (pos >= ready_count) res.st = ST_NOT_FOUND;
        else remove_slot(pos);
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, out_pid %0d status %0d", $time, out_pid, status);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_pid !== want.pid) begin
          $display("%0t: out_pid expected %0d, got %0d", $time, want.pid, out_pid);
          mismatch_count++;
        end
        if (status !== want.st) begin
          $display("%0t: status expected %0d, got %0d", $time, want.st, status);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_request(logic [OP_W-1:0] req_op, logic [PID_W-1:0] req_pid,
                              logic [PRIO_W-1:0] req_prio, logic req_rot);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    op             = req_op;
    entry_pid      = req_pid;
    entry_priority = req_prio;
    rotate         = req_rot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(predict_outcome(req_op, req_pid, req_prio, req_rot));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    wait (expected_results.size() == 0);
    @(negedge clk);
  endtask

  // Removes mostly name an id that is queued, so that hits outnumber misses.
  task automatic send_random_request(int enqueue_pct, int dequeue_pct);
    int                pick;
    logic [OP_W-1:0]   req_op;
    logic [PID_W-1:0]  req_pid;
    logic [PRIO_W-1:0] req_prio;
    pick = $urandom_range(0, 99);
    if (pick < enqueue_pct) req_op = OP_ENQUEUE;
    else if (pick < enqueue_pct + dequeue_pct) req_op = OP_DEQUEUE;
    else if (pick < 98) req_op = OP_REMOVE;
    else req_op = OP_UNUSED;
    req_pid = PID_W'($urandom_range(0, 63));
    if (req_op == OP_REMOVE && ready_count > 0 && $urandom_range(0, 3) != 0)
      req_pid = ready_pid[$urandom_range(0, ready_count - 1)];
    if ($urandom_range(0, 19) == 0) req_prio = $urandom_range(0, 1) ? 3'd7 : 3'd0;
    else if ($urandom_range(0, 1)) req_prio = PRIO_W'($urandom_range(1, 3));
    else req_prio = PRIO_W'($urandom_range(1, 6));
    send_request(req_op, req_pid, req_prio, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_empty_queue();
    send_request(OP_DEQUEUE, 6'd0, 3'd0, 1'b0);
    send_request(OP_DEQUEUE, 6'd63, 3'd7, 1'b1);
    send_request(OP_REMOVE, 6'd63, 3'd7, 1'b0);
    send_request(OP_UNUSED, 6'd63, 3'd7, 1'b1);
  endtask

  task automatic test_priority_order();
    send_request(OP_ENQUEUE, 6'd63, 3'd7, 1'b0);
    send_request(OP_ENQUEUE, 6'd0, 3'd0, 1'b1);
    send_request(OP_ENQUEUE, 6'd21, 3'd3, 1'b0);
    send_request(OP_ENQUEUE, 6'd42, 3'd3, 1'b0);
    send_request(OP_ENQUEUE, 6'd5, 3'd1, 1'b0);
    send_request(OP_ENQUEUE, 6'd6, 3'd6, 1'b0);
    send_request(OP_DEQUEUE, 6'd0, 3'd0, 1'b1);
    send_request(OP_DEQUEUE, 6'd0, 3'd0, 1'b1);
    send_request(OP_DEQUEUE, 6'd0, 3'd0, 1'b1);
  endtask

  task automatic test_remove_duplicates();
    send_request(OP_ENQUEUE, 6'd9, 3'd2, 1'b0);
    send_request(OP_ENQUEUE, 6'd9, 3'd4, 1'b0);
    send_request(OP_REMOVE, 6'd9, 3'd0, 1'b0);
    send_request(OP_REMOVE, 6'd9, 3'd0, 1'b0);
    send_request(OP_REMOVE, 6'd9, 3'd0, 1'b0);
    send_request(OP_REMOVE, 6'd21, 3'd0, 1'b0);
    send_request(OP_DEQUEUE, 6'd0, 3'd0, 1'b0);
    send_request(OP_DEQUEUE, 6'd0, 3'd0, 1'b0);
  endtask

  // A filling stretch drives the queue into overflow before it is drained again.
  task automatic test_random_traffic(int gap_pct, int stall_pct);
    sender_gap_pct     = gap_pct;
    receiver_stall_pct = stall_pct;
    repeat (110) send_random_request(85, 7);
    repeat (40) send_random_request(10, 75);
    wait_for_results();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    sender_gap_pct     = 27;
    receiver_stall_pct = 52;
    test_empty_queue();
    test_priority_order();
    wait_for_results();
    test_remove_duplicates();
    test_random_traffic(27, 52);
    test_random_traffic(52, 27);
    test_random_traffic(0, 0);
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
